### sv/generational_handle_allocator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the generational handle allocator
// Each macro expects clk and rst_n in scope at the place of use.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// Check a condition at every edge out of reset.
`define GHA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check a consequent at the same edge as its trigger.
`define GHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent at the edge after its trigger.
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared codes, widths and types of the generational handle allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gha_pkg;

  // Default configuration
  localparam int SLOT_COUNT_DEF = 1024;
  localparam int GEN_BITS_DEF   = 16;
  localparam int IDX_W_DEF      = $clog2(SLOT_COUNT_DEF);

  // Request operation codes
  localparam int FUNC_W = 2;
  localparam logic [FUNC_W-1:0] FUNC_CREATE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DESTROY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd2;

  // Response status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ALIVE = 2'd2;

  // Request sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

### sv/gha_ifs.sv
// ----------------------------------------------------------------------------
// Allocator channels
// Request and response channels with a valid/ready transfer handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gha_req_if #(
  parameter int IDX_W = gha_pkg::IDX_W_DEF,
  parameter int GEN_W = gha_pkg::GEN_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::FUNC_W-1:0]  func;
  logic [IDX_W-1:0]            handle_index;
  logic [GEN_W-1:0]            handle_generation;

  modport source (output valid, func, handle_index, handle_generation, input ready);
  modport sink   (input valid, func, handle_index, handle_generation, output ready);
endinterface

interface gha_rsp_if #(
  parameter int IDX_W = gha_pkg::IDX_W_DEF,
  parameter int GEN_W = gha_pkg::GEN_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::STATUS_W-1:0]  status;
  logic [IDX_W-1:0]              slot_index;
  logic [GEN_W-1:0]              slot_generation;
  logic                          is_alive;

  modport source (output valid, status, slot_index, slot_generation, is_alive,
                  input ready);
  modport sink   (input valid, status, slot_index, slot_generation, is_alive,
                  output ready);
endinterface

### sv/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and register the read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator
// A request is taken in the idle state with the slot memory read and done in
// the execute state with its write back, before the next one is taken. The
// response is valid the cycle after execution and is held until taken; a new
// request is accepted while it waits. Reset (synchronous, rst_n low) empties
// the free stack and rewinds the fresh slot counter; memories are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "generational_handle_allocator_defines.svh"

module generational_handle_allocator #(
  parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  gha_req_if.sink     in_if,
  gha_rsp_if.source   out_if
);

  import gha_pkg::*;

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int SLOT_W = GEN_BITS + 1;          // {alive, generation}
  localparam int STK_W  = IDX_W + GEN_BITS;      // {index, generation}
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

  // Sequencer and allocator state
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     free_count_r, free_count_nxt;
  logic [IDX_W-1:0]     next_fresh_r, next_fresh_nxt;

  // Captured request
  logic [FUNC_W-1:0]    func_r;
  logic [IDX_W-1:0]     idx_r;
  logic [GEN_BITS-1:0]  gen_r;

  // Response register
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r;
  logic [IDX_W-1:0]     out_slot_index_r;
  logic [GEN_BITS-1:0]  out_slot_gen_r;
  logic                 out_is_alive_r;

  // Memory ports
  logic                 slot_we;
  logic [IDX_W-1:0]     slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]    slot_wdata, slot_rdata;
  logic                 stk_we;
  logic [IDX_W-1:0]     stk_waddr, stk_raddr;
  logic [STK_W-1:0]     stk_wdata, stk_rdata;

  // Execute-cycle results
  logic                 in_ready;
  logic                 in_xfer;
  logic                 fire;
  logic                 live;
  logic                 stk_full;
  logic [STATUS_W-1:0]  status_nxt;
  logic [IDX_W-1:0]     res_idx;
  logic [GEN_BITS-1:0]  res_gen;
  logic                 res_alive;

  // Assertion terms
  logic                 create_done;
  logic                 destroy_done;
  logic                 exhaust_now;
  logic                 space_gone;

  // Slot table: alive bit and generation per slot
  gha_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_addr (slot_raddr),
    .rd_data (slot_rdata)
  );

  // Free stack: freed index with its already bumped generation
  gha_ram #(
    .WIDTH (STK_W),
    .DEPTH (SLOT_COUNT)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs; hold off requests while in reset
  always_comb begin
    in_ready = 1'b0;
    fire     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = rst_n;
      ST_EXEC: fire = !out_valid_r || out_if.ready;
      default: begin
        in_ready = 1'b0;
        fire     = 1'b0;
      end
    endcase
  end

  assign in_xfer = in_if.valid && in_ready;

  // Read at the incoming index on transfer, then hold it while stalled
  assign slot_raddr = (state_r == ST_IDLE) ? in_if.handle_index : idx_r;
  assign stk_raddr  = IDX_W'(free_count_r - 1'b1);
  assign stk_waddr  = free_count_r[IDX_W-1:0];
  assign stk_full   = (free_count_r == FULL_CNT);

  // Handle is live only if created, alive and of the same generation
  assign live = (idx_r < LAST_IDX) && (idx_r < next_fresh_r) &&
                slot_rdata[GEN_BITS] && (slot_rdata[GEN_BITS-1:0] == gen_r);

  // Execute the request
  always_comb begin
    status_nxt     = STATUS_DONE;
    res_idx        = idx_r;
    res_gen        = gen_r;
    res_alive      = 1'b0;
    free_count_nxt = free_count_r;
    next_fresh_nxt = next_fresh_r;
    slot_we        = 1'b0;
    slot_waddr     = idx_r;
    slot_wdata     = {1'b0, slot_rdata[GEN_BITS-1:0] + 1'b1};
    stk_we         = 1'b0;
    stk_wdata      = {idx_r, slot_rdata[GEN_BITS-1:0] + 1'b1};
    unique case (func_r)
      FUNC_CREATE: begin
        if (free_count_r != '0) begin
          // Pop the most recently freed slot
          res_idx        = stk_rdata[STK_W-1:GEN_BITS];
          res_gen        = stk_rdata[GEN_BITS-1:0];
          free_count_nxt = free_count_r - 1'b1;
          slot_we        = fire;
          slot_waddr     = stk_rdata[STK_W-1:GEN_BITS];
          slot_wdata     = {1'b1, stk_rdata[GEN_BITS-1:0]};
        end else if (next_fresh_r >= LAST_IDX) begin
          status_nxt = STATUS_EXHAUSTED;
        end else begin
          // Take a fresh slot at generation zero
          res_idx        = next_fresh_r;
          res_gen        = '0;
          next_fresh_nxt = next_fresh_r + 1'b1;
          slot_we        = fire;
          slot_waddr     = next_fresh_r;
          slot_wdata     = {1'b1, {GEN_BITS{1'b0}}};
        end
      end
      FUNC_DESTROY: begin
        if (!live) begin
          status_nxt = STATUS_NOT_ALIVE;
        end else begin
          // Kill, bump generation, push on the free stack
          slot_we = fire;
          if (!stk_full) begin
            stk_we         = fire;
            free_count_nxt = free_count_r + 1'b1;
          end
        end
      end
      FUNC_CHECK: begin
        res_alive = live;
      end
      default: begin
        status_nxt = STATUS_DONE;
      end
    endcase
  end

  // Response handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      free_count_r <= '0;
      next_fresh_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        free_count_r <= free_count_nxt;
        next_fresh_r <= next_fresh_nxt;
      end
    end
  end

  // Capture the request and load the response
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= in_if.func;
      idx_r  <= in_if.handle_index;
      gen_r  <= in_if.handle_generation;
    end
    if (fire) begin
      out_status_r     <= status_nxt;
      out_slot_index_r <= res_idx;
      out_slot_gen_r   <= res_gen;
      out_is_alive_r   <= res_alive;
    end
  end

  assign in_if.ready            = in_ready;
  assign out_if.valid           = out_valid_r;
  assign out_if.status          = out_status_r;
  assign out_if.slot_index      = out_slot_index_r;
  assign out_if.slot_generation = out_slot_gen_r;
  assign out_if.is_alive        = out_is_alive_r;

  // Qualify the executed request for the checks below
  assign create_done  = fire && (func_r == FUNC_CREATE) && (status_nxt == STATUS_DONE);
  assign destroy_done = fire && (func_r == FUNC_DESTROY) && (status_nxt == STATUS_DONE);
  assign exhaust_now  = fire && (status_nxt == STATUS_EXHAUSTED);
  assign space_gone   = (free_count_r == '0) && (next_fresh_r == LAST_IDX);

  // Every slot on the free stack was once a fresh slot
  `GHA_ASSERT_ALWAYS(a_free_within_fresh, free_count_r <= CNT_W'(next_fresh_r), "stack too deep")
  // A created handle lies below the fresh slot counter
  `GHA_ASSERT_NEXT(a_create_in_range, create_done, out_slot_index_r < next_fresh_r, "bad slot")
  // Exhaustion only with an empty stack and every slot below the last index handed out
  `GHA_ASSERT_NOW(a_exhaust_when_full, exhaust_now, space_gone, "exhaustion with slots left")
  // A successful destroy grows the free stack by one
  `GHA_ASSERT_NEXT(a_destroy_pushes, destroy_done, free_count_r == $past(free_count_r)+1'b1, "no push")

endmodule

### tb/gha_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator scoreboard
// Keeps its own copy of the slot tables, free stack and fresh-slot counter,
// works out the response of every accepted request and compares each
// response transfer with the oldest outstanding expectation.
// ----------------------------------------------------------------------------

package gha_tb_pkg;
  import gha_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int IDX_W = IDX_W_DEF;
  localparam int GEN_W = GEN_BITS_DEF;

  // Operation code with no defined function
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot_index;
    logic [GEN_W-1:0]    slot_generation;
    logic                is_alive;
  } alloc_rsp_t;

  class alloc_scoreboard;
    logic [GEN_W-1:0] gen_tab [SLOTS];
    bit               alive_tab [SLOTS];
    logic [IDX_W-1:0] free_lifo [SLOTS];
    int unsigned      free_depth;
    int unsigned      fresh_next;
    alloc_rsp_t       rsp_queue [$];

    int unsigned mismatches;
    int unsigned checked;
    int unsigned n_fresh;
    int unsigned n_reused;
    int unsigned n_destroyed;
    int unsigned n_ignored;
    int unsigned n_exhausted;
    int unsigned n_checks;
    int unsigned n_alive_hits;

    function new();
      free_depth = 0;
      fresh_next = 0;
      mismatches = 0;
      checked = 0;
      n_fresh = 0;
      n_reused = 0;
      n_destroyed = 0;
      n_ignored = 0;
      n_exhausted = 0;
      n_checks = 0;
      n_alive_hits = 0;
    endfunction

    // A handle is live only for a created, alive slot with a matching tag
    function bit handle_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
      if (idx >= SLOTS - 1) return 1'b0;
      if (idx >= fresh_next) return 1'b0;
      return alive_tab[idx] && (gen_tab[idx] == gen);
    endfunction

    // Apply one accepted request and queue its response
    function alloc_rsp_t note_request(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                                      logic [GEN_W-1:0] gen);
      alloc_rsp_t       r;
      logic [IDX_W-1:0] slot;
      r.status          = STATUS_DONE;
      r.slot_index      = idx;
      r.slot_generation = gen;
      r.is_alive        = 1'b0;
      case (f)
        FUNC_CREATE: begin
          if (free_depth > 0) begin
            free_depth--;
            slot = free_lifo[free_depth];
            alive_tab[slot] = 1'b1;
            r.slot_index = slot;
            r.slot_generation = gen_tab[slot];
            n_reused++;
          end else if (fresh_next >= SLOTS - 1) begin
            r.status = STATUS_EXHAUSTED;
            n_exhausted++;
          end else begin
            slot = IDX_W'(fresh_next);
            fresh_next++;
            gen_tab[slot] = '0;
            alive_tab[slot] = 1'b1;
            r.slot_index = slot;
            r.slot_generation = '0;
            n_fresh++;
          end
        end
        FUNC_DESTROY: begin
          if (!handle_live(idx, gen)) begin
            r.status = STATUS_NOT_ALIVE;
            n_ignored++;
          end else begin
            alive_tab[idx] = 1'b0;
            gen_tab[idx] = gen_tab[idx] + 1'b1;
            if (free_depth < SLOTS) begin
              free_lifo[free_depth] = idx;
              free_depth++;
            end
            n_destroyed++;
          end
        end
        FUNC_CHECK: begin
          r.is_alive = handle_live(idx, gen);
          n_checks++;
          if (r.is_alive) n_alive_hits++;
        end
        default: ;
      endcase
      rsp_queue.insert(rsp_queue.size(), r);
      return r;
    endfunction

    function void report(string what, alloc_rsp_t want, alloc_rsp_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] %s: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                 $time, what, want.status, want.slot_index, want.slot_generation,
                 want.is_alive, got.status, got.slot_index, got.slot_generation,
                 got.is_alive);
    endfunction

    // Compare one response transfer with the oldest expectation
    function void check_response(alloc_rsp_t got);
      alloc_rsp_t want;
      if (rsp_queue.size() == 0) begin
        want = '0;
        report("response with nothing outstanding", want, got);
        return;
      end
      want = rsp_queue.pop_front();
      checked++;
      if ((got.status !== want.status) || (got.slot_index !== want.slot_index) ||
          (got.slot_generation !== want.slot_generation) ||
          (got.is_alive !== want.is_alive))
        report("response mismatch", want, got);
    endfunction

    function int unsigned pending();
      return rsp_queue.size();
    endfunction
  endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Handle allocator testbench
// Drives create, destroy and check requests through the request channel,
// predicts every response with the scoreboard and checks the response
// channel in order. Covers directed corner cases, churn, filling the slot
// space to exhaustion, repeated reuse of one slot, and random idling and
// back-pressure on both channels.
// ----------------------------------------------------------------------------

module tb_top;
  import gha_pkg::*;
  import gha_tb_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } handle_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gha_req_if req_ch ();
  gha_rsp_if rsp_ch ();

  generational_handle_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (rsp_ch)
  );

  alloc_scoreboard sb = new();

  handle_t     live_handles [$];
  handle_t     stale_handles [$];
  bit          tx_idle_on;
  bit          rx_idle_on;
  int          rx_hold_len = 0;
  int unsigned items_sent = 0;

  // Clock
  always #4 clk = ~clk;

  // Run limit
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Send one request, note it at its transfer and track handles
  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                          input logic [GEN_W-1:0] gen);
    int         gap;
    int         i;
    alloc_rsp_t want;
    handle_t    h;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid             <= 1'b1;
    req_ch.func              <= f;
    req_ch.handle_index      <= idx;
    req_ch.handle_generation <= gen;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    want = sb.note_request(f, idx, gen);
    items_sent++;
    h.idx = want.slot_index;
    h.gen = want.slot_generation;
    if (f == FUNC_CREATE && want.status == STATUS_DONE) begin
      live_handles.insert(live_handles.size(), h);
    end else if (f == FUNC_DESTROY && want.status == STATUS_DONE) begin
      // newest handles sit at the back
      for (i = live_handles.size() - 1; i >= 0; i--) begin
        if (live_handles[i].idx == idx) begin
          live_handles.delete(i);
          break;
        end
      end
      stale_handles.insert(stale_handles.size(), h);
      if (stale_handles.size() > 64) void'(stale_handles.pop_front());
    end
  endtask

  // Random handle biased to the invalid index and the fresh-slot boundary
  function automatic handle_t any_handle();
    handle_t h;
    case ($urandom_range(0, 3))
      0:       h.idx = '1;
      1:       h.idx = IDX_W'(sb.fresh_next + $urandom_range(0, 2));
      default: h.idx = IDX_W'($urandom);
    endcase
    h.gen = ($urandom_range(0, 3) == 0) ? GEN_W'($urandom_range(0, 3)) : GEN_W'($urandom);
    return h;
  endfunction

  // Handle that was live once, or a live one with a flipped tag bit
  function automatic handle_t stale_handle();
    handle_t h;
    int      pick;
    if (stale_handles.size() > 0 && $urandom_range(0, 1) == 1) begin
      h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
    end else if (live_handles.size() > 0) begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      pick = $urandom_range(0, GEN_W - 1);
      h.gen[pick] = ~h.gen[pick];
    end else begin
      h = any_handle();
    end
    return h;
  endfunction

  // One random request; the rest of the percentages goes to noise
  task automatic issue_random(input int pc_create, input int pc_destroy, input int pc_check);
    int      roll;
    handle_t h;
    roll = $urandom_range(0, 99);
    h = any_handle();
    if (roll < pc_create ||
        (live_handles.size() == 0 && roll < pc_create + pc_destroy + pc_check)) begin
      send_req(FUNC_CREATE, h.idx, h.gen);
    end else if (roll < pc_create + pc_destroy) begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      send_req(FUNC_DESTROY, h.idx, h.gen);
    end else if (roll < pc_create + pc_destroy + pc_check) begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      send_req(FUNC_CHECK, h.idx, h.gen);
    end else begin
      case ($urandom_range(0, 4))
        0: begin
          h = stale_handle();
          send_req(FUNC_DESTROY, h.idx, h.gen);
        end
        1:       send_req(FUNC_DESTROY, h.idx, h.gen);
        2: begin
          h = stale_handle();
          send_req(FUNC_CHECK, h.idx, h.gen);
        end
        3:       send_req(FUNC_CHECK, h.idx, h.gen);
        default: send_req(FUNC_UNUSED, h.idx, h.gen);
      endcase
    end
  endtask

  // Random stretch; redraw idling every 64 requests, stop early on exhaustion goal
  task automatic run_mix(input int n, input int pc_create, input int pc_destroy,
                         input int pc_check, input bit vary_idle, input int exhaust_goal);
    int k;
    for (k = 0; k < n; k++) begin
      if (exhaust_goal > 0 && sb.n_exhausted >= exhaust_goal) break;
      if (vary_idle && (k % 64) == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      issue_random(pc_create, pc_destroy, pc_check);
    end
  endtask

  // Drop the request and wait until every response is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Corner cases in a fixed order
  task automatic run_directed();
    send_req(FUNC_CHECK, '0, '0);           // never-created slot
    send_req(FUNC_DESTROY, '0, '0);         // destroy before any create
    send_req(FUNC_UNUSED, '1, '1);          // unused operation
    send_req(FUNC_CREATE, '1, '1);          // fresh slot 0, payload ignored
    send_req(FUNC_CREATE, '0, '0);          // fresh slot 1
    send_req(FUNC_CHECK, 10'd0, 16'd0);     // alive
    send_req(FUNC_CHECK, 10'd0, 16'hFFFF);  // tag mismatch
    send_req(FUNC_CHECK, '1, '0);           // invalid handle
    send_req(FUNC_DESTROY, '1, '1);         // destroy of invalid handle
    send_req(FUNC_DESTROY, 10'd1, 16'd0);   // live destroy
    send_req(FUNC_DESTROY, 10'd1, 16'd0);   // double destroy
    send_req(FUNC_CHECK, 10'd1, 16'd1);     // dead slot, new tag
    send_req(FUNC_CREATE, '0, '0);          // reuse of slot 1
    send_req(FUNC_CHECK, 10'd1, 16'd1);
    send_req(FUNC_DESTROY, 10'd0, 16'd0);
    send_req(FUNC_DESTROY, 10'd1, 16'd1);
    send_req(FUNC_CREATE, '0, '0);          // last freed comes back first
    send_req(FUNC_CREATE, '0, '0);
    send_req(FUNC_CREATE, '0, '0);          // stack empty, fresh slot 2
    send_req(FUNC_UNUSED, '0, '0);
    send_req(FUNC_CHECK, 10'd2, 16'h8000);  // tag mismatch in top bit
    send_req(FUNC_CHECK, 10'd1000, 16'd0);  // far beyond the fresh slot
  endtask

  // Cycle one slot through create and destroy back to back
  task automatic churn_one_slot();
    handle_t h;
    repeat (10) begin
      send_req(FUNC_CREATE, IDX_W'($urandom), GEN_W'($urandom));
      h = live_handles[$];
      send_req(FUNC_DESTROY, h.idx, h.gen);
    end
    send_req(FUNC_CHECK, h.idx, h.gen);
    send_req(FUNC_CHECK, h.idx, h.gen + 1'b1);
  endtask

  // Response side: random stalls, one long hold-off on request
  initial begin : rsp_sink
    int         stall;
    alloc_rsp_t got;
    rsp_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        stall = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 14) : 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      got.status          = rsp_ch.status;
      got.slot_index      = rsp_ch.slot_index;
      got.slot_generation = rsp_ch.slot_generation;
      got.is_alive        = rsp_ch.is_alive;
      sb.check_response(got);
    end
  end

  // Stimulus
  initial begin : stimulus
    req_ch.valid             <= 1'b0;
    req_ch.func              <= FUNC_CREATE;
    req_ch.handle_index      <= '0;
    req_ch.handle_generation <= '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // balanced churn
    run_mix(30, 40, 25, 20, 1'b1, 0);

    // hold the response side while requests keep coming
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    rx_hold_len = 300;
    run_mix(24, 40, 25, 20, 1'b0, 0);

    // pause until every response is back
    wait_drained();

    // fill the slot space until creates run out repeatedly
    run_mix(1400, 97, 1, 1, 1'b1, 8);

    // reuse one slot over and over with no idling
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    churn_one_slot();

    // drain with destroys
    run_mix(30, 10, 60, 20, 1'b1, 0);

    wait_drained();
    repeat (16) @(posedge clk);

    $display("run: %0d requests sent, %0d responses checked, %0d mismatches",
             items_sent, sb.checked, sb.mismatches);
    $display("run: fresh %0d reuse %0d free %0d ignore %0d exhaust %0d check %0d/%0d",
             sb.n_fresh, sb.n_reused, sb.n_destroyed, sb.n_ignored, sb.n_exhausted,
             sb.n_alive_hits, sb.n_checks);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
